// ===== sv/signed_radix_to_symbols_unit_assert.svh =====
// Assertion macros shared by the signed radix to symbols unit.
`ifndef SIGNED_RADIX_TO_SYMBOLS_UNIT_ASSERT_SVH
`define SIGNED_RADIX_TO_SYMBOLS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SRTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SRTS_ASSERT_NEVER(lbl, cond, msg) `SRTS_ASSERT(lbl, !(cond), msg)
`else
`define SRTS_ASSERT(lbl, prop, msg)
`define SRTS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== sv/srts_pkg.sv =====
// Shared constants and helper functions for the signed radix to symbols unit.
package srts_pkg;

  localparam int unsigned MAX_RADIX_DEF  = 16;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned RADIX_W       = 5;
  localparam int unsigned SYM_W         = 8;
  localparam int unsigned ALPHA_SYMS    = 16;
  localparam int unsigned ALPHA_IDX_W   = 4;
  localparam int unsigned ALPHA_W       = ALPHA_SYMS * SYM_W;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned DIV_STEP_BITS = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HI = 2'd2;

  localparam logic [SYM_W-1:0] SYM_SPACE = 8'd32;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'd43;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'd45;
  localparam logic [SYM_W-1:0] SYM_DEL   = 8'd127;

  function automatic logic [SYM_W-1:0] sym_at(input logic [ALPHA_W-1:0] alpha,
                                              input logic [ALPHA_IDX_W-1:0] idx);
    sym_at = alpha[idx*SYM_W +: SYM_W];
  endfunction

  // A digit symbol must be printable and must not look like a sign.
  function automatic logic sym_bad(input logic [SYM_W-1:0] s);
    sym_bad = (s <= SYM_SPACE) || s[SYM_W-1] || (s == SYM_DEL) ||
              (s == SYM_PLUS) || (s == SYM_MINUS);
  endfunction

endpackage

// ===== sv/srts_div.sv =====
// Iterative divider: unsigned value by a small radix, several quotient bits per cycle.
module srts_div
  import srts_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned MAX_RADIX  = MAX_RADIX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [VALUE_BITS-1:0]         dividend_i,
  input  logic [RADIX_W-1:0]            divisor_i,
  output logic                          done_o,
  output logic [VALUE_BITS-1:0]         quot_o,
  output logic [$clog2(MAX_RADIX)-1:0]  rem_o
);

  localparam int unsigned DIG_W  = $clog2(MAX_RADIX);
  localparam int unsigned STEPS  = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int unsigned DIV_W  = STEPS * DIV_STEP_BITS;
  localparam int unsigned STEP_W = $clog2(STEPS + 1);

  logic [DIV_W-1:0]   work_q, work_d;
  logic [RADIX_W-1:0] rem_q, rem_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               done_q, done_d;

  always_comb begin
    logic [DIV_STEP_BITS-1:0] chunk;
    logic [DIV_STEP_BITS-1:0] qbits;
    logic [RADIX_W-1:0]       r;
    chunk  = work_q[DIV_W-1 -: DIV_STEP_BITS];
    qbits  = '0;
    r      = rem_q;
    for (int b = DIV_STEP_BITS - 1; b >= 0; b--) begin
      r = {r[RADIX_W-2:0], chunk[b]};
      if (r >= divisor_i) begin
        r        = r - divisor_i;
        qbits[b] = 1'b1;
      end
    end
    work_d = work_q;
    rem_d  = rem_q;
    step_d = step_q;
    done_d = 1'b0;
    if (start_i) begin
      work_d = DIV_W'(dividend_i);
      rem_d  = '0;
      step_d = STEP_W'(STEPS);
    end else if (step_q != '0) begin
      work_d = {work_q[DIV_W-DIV_STEP_BITS-1:0], qbits};
      rem_d  = r;
      step_d = step_q - 1'b1;
      done_d = (step_q == STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = work_q[VALUE_BITS-1:0];
  assign rem_o  = rem_q[DIG_W-1:0];

endmodule

// ===== sv/signed_radix_to_symbols_unit.sv =====
// Top level of the signed radix to symbols unit: sequencer, digit stack and output register.
// One request first checks the alphabet one symbol at a time, then divides out one digit at a
// time in the shared divider, then emits one symbol per cycle when the output is not
// stalled. A new request is taken only after the last symbol of the previous one has been
// loaded into the output register. An invalid radix or alphabet produces no symbols and
// returns to idle from the alphabet check.
`include "signed_radix_to_symbols_unit_assert.svh"

module signed_radix_to_symbols_unit
  import srts_pkg::*;
#(
  parameter int unsigned MAX_RADIX  = MAX_RADIX_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [SYM_W-1:0]             symbol_o,
  output logic                         last_o
);

  localparam int unsigned DIG_W = $clog2(MAX_RADIX);
  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [RADIX_W-1:0]    radix_q;
  logic [ALPHA_W-1:0]    alpha_q;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic                  ok_q, ok_d;
  logic [RADIX_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [SYM_W-1:0]      sym_q, sym_d;
  logic                  last_q, last_d;
  logic [DIG_W-1:0]      stk_q [VALUE_BITS];
  logic                  push, pop;

  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIG_W-1:0]      div_rem;

  logic                  in_acc;
  logic                  slot_free;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= '0;
      alpha_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RADIX:    radix_q <= cfg_data_i[RADIX_W-1:0];
        CFG_ALPHA_LO: alpha_q[CFG_DATA_W-1:0] <= cfg_data_i;
        CFG_ALPHA_HI: alpha_q[ALPHA_W-1:CFG_DATA_W] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [SYM_W-1:0] s;
    logic             bad;
    state_d     = state_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    ok_d        = ok_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    sym_d       = sym_q;
    last_d      = last_q;
    div_start   = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    s           = sym_at(alpha_q, idx_q[ALPHA_IDX_W-1:0]);
    bad         = sym_bad(s);
    for (int j = 0; j < MAX_RADIX; j++) begin
      if ((RADIX_W'(j) > idx_q) && (RADIX_W'(j) < radix_q) &&
          (sym_at(alpha_q, ALPHA_IDX_W'(j)) == s)) begin
        bad = 1'b1;
      end
    end

    if (slot_free) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          neg_d   = value_i[VALUE_BITS-1];
          mag_d   = value_i[VALUE_BITS-1] ? (~value_i + 1'b1) : value_i;
          ok_d    = (radix_q >= RADIX_W'(2)) && (radix_q <= RADIX_W'(MAX_RADIX));
          idx_d   = '0;
          cnt_d   = '0;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!ok_q) begin
          state_d = ST_IDLE;
        end else if (idx_q == radix_q) begin
          div_start = 1'b1;
          state_d   = ST_DIVIDE;
        end else begin
          ok_d  = !bad;
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          push  = 1'b1;
          cnt_d = cnt_q + 1'b1;
          mag_d = div_quot;
          if ((div_quot != '0) && (cnt_q < CNT_W'(VALUE_BITS - 1))) begin
            div_start = 1'b1;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (neg_q) begin
            sym_d  = SYM_MINUS;
            last_d = 1'b0;
            neg_d  = 1'b0;
          end else begin
            sym_d  = sym_at(alpha_q, ALPHA_IDX_W'(stk_q[0]));
            last_d = (cnt_q == CNT_W'(1));
            pop    = 1'b1;
            cnt_d  = cnt_q - 1'b1;
            if (cnt_q == CNT_W'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ok_q        <= 1'b0;
      neg_q       <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ok_q        <= ok_d;
      neg_q       <= neg_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    sym_q  <= sym_d;
    last_q <= last_d;
    if (push) begin
      stk_q[0] <= div_rem;
      for (int k = 1; k < VALUE_BITS; k++) begin
        stk_q[k] <= stk_q[k-1];
      end
    end else if (pop) begin
      for (int k = 0; k < VALUE_BITS - 1; k++) begin
        stk_q[k] <= stk_q[k+1];
      end
    end
  end

  srts_div #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_RADIX  (MAX_RADIX)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_d),
    .divisor_i  (radix_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign symbol_o    = sym_q;
  assign last_o      = last_q;

  `SRTS_ASSERT(a_accept_starts_check, in_acc |=> (state_q == ST_CHECK), "request did not start a check")
  `SRTS_ASSERT(a_rem_below_radix, (state_q == ST_DIVIDE && div_done) |-> (RADIX_W'(div_rem) < radix_q), "digit not below radix")
  `SRTS_ASSERT_NEVER(a_emit_empty, (state_q == ST_EMIT) && (cnt_q == '0), "emit with an empty digit stack")
  `SRTS_ASSERT_NEVER(a_cnt_overflow, cnt_q > CNT_W'(VALUE_BITS), "digit count beyond the stack depth")
  `SRTS_ASSERT(a_check_index, (state_q == ST_CHECK) |-> (idx_q <= radix_q), "alphabet check index past radix")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the signed radix to symbols unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import srts_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;
  localparam logic [ALPHA_W-1:0] BIN_DIGITS = {64'h0, 64'h3130};
  localparam logic [ALPHA_W-1:0] DEC_DIGITS = {64'h3938, 64'h3736_3534_3332_3130};
  localparam logic [ALPHA_W-1:0] HEX_DIGITS = {"FEDCBA98", "76543210"};
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLDOFF_CYCLES = 400;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } symbol_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic signed [31:0]    value_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [SYM_W-1:0]      symbol_o;
  logic                  last_o;

  logic [RADIX_W-1:0] radix_q = '0;
  logic [ALPHA_W-1:0] alphabet_q = '0;
  symbol_t            pending_symbols[$];
  int                 error_count = 0;
  int                 sender_idle_pct = 0;
  int                 stall_pct = 0;
  bit                 holdoff_req = 1'b0;
  int                 holdoff_left = 0;

  signed_radix_to_symbols_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .symbol_o    (symbol_o),
    .last_o      (last_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit alphabet_valid();
    logic [SYM_W-1:0] s;
    if (radix_q < 2 || radix_q > 16) return 1'b0;
    for (int i = 0; i < radix_q; i++) begin
      s = alphabet_q[i*SYM_W +: SYM_W];
      if (s <= SYM_SPACE || s[SYM_W-1] || s == SYM_DEL || s == SYM_PLUS || s == SYM_MINUS)
        return 1'b0;
      for (int j = i + 1; j < radix_q; j++) begin
        if (alphabet_q[j*SYM_W +: SYM_W] == s) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void predict_symbols(input logic signed [31:0] v);
    logic [63:0] mag;
    logic [3:0]  digits[32];
    int          nd;
    if (!alphabet_valid()) return;
    mag = {{32{v[31]}}, v};
    if (v[31]) mag = 64'd0 - mag;
    nd = 0;
    do begin
      digits[nd] = 4'(mag % radix_q);
      mag = mag / radix_q;
      nd++;
    end while (mag != 0 && nd < 32);
    if (v[31]) pending_symbols.push_back(symbol_t'{symbol: SYM_MINUS, last: 1'b0});
    for (int k = nd - 1; k >= 0; k--) begin
      pending_symbols.push_back(symbol_t'{symbol: alphabet_q[digits[k]*SYM_W +: SYM_W],
                                          last: (k == 0)});
    end
  endfunction

  function automatic logic [ALPHA_W-1:0] make_alphabet();
    logic [ALPHA_W-1:0] a;
    bit                 used[256];
    int                 s;
    for (int i = 0; i < ALPHA_SYMS; i++) begin
      do s = $urandom_range(33, 126);
      while (s == SYM_PLUS || s == SYM_MINUS || used[s]);
      used[s] = 1'b1;
      a[i*SYM_W +: SYM_W] = s[SYM_W-1:0];
    end
    return a;
  endfunction

  function automatic logic [SYM_W-1:0] bad_symbol(input logic [ALPHA_W-1:0] a);
    case ($urandom_range(5))
      0: return SYM_W'($urandom_range(0, 32));
      1: return SYM_W'($urandom_range(128, 255));
      2: return SYM_DEL;
      3: return SYM_PLUS;
      4: return SYM_MINUS;
      default: return a[$urandom_range(15)*SYM_W +: SYM_W];
    endcase
  endfunction

  function automatic logic signed [31:0] rand_value();
    logic signed [31:0] s;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return '0;
          1: return -32'sd1;
          2: return VALUE_MAX;
          default: return VALUE_MIN;
        endcase
      end
      1, 2: begin
        s = $urandom_range(0, 300);
        return $urandom_range(1) ? -s : s;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_RADIX:    radix_q = data[RADIX_W-1:0];
      CFG_ALPHA_LO: alphabet_q[63:0] = data;
      CFG_ALPHA_HI: alphabet_q[127:64] = data;
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [RADIX_W-1:0] r, input logic [ALPHA_W-1:0] a);
    write_reg(CFG_RADIX, CFG_DATA_W'(r));
    write_reg(CFG_ALPHA_LO, a[63:0]);
    write_reg(CFG_ALPHA_HI, a[127:64]);
  endtask

  task automatic send_value(input logic signed [31:0] v);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i);
    while (in_stall_o);
    predict_symbols(v);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_symbols.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (holdoff_req) begin
      holdoff_left = HOLDOFF_CYCLES;
      holdoff_req  = 1'b0;
    end
    if (holdoff_left > 0) begin
      out_stall_i <= 1'b1;
      holdoff_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    symbol_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_symbols.size() == 0) begin
        $error("unexpected result: symbol %0d last %0d", symbol_o, last_o);
        error_count++;
      end else begin
        want = pending_symbols.pop_front();
        if (symbol_o !== want.symbol) begin
          $error("symbol: expected %0d, got %0d", want.symbol, symbol_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          error_count++;
        end
      end
    end
  end

  task automatic test_reset_radix_zero();
    send_value(32'sd7);
    send_value(-32'sd1);
    wait_drained();
  endtask

  task automatic test_decimal_values();
    apply_config(5'd10, DEC_DIGITS);
    send_value('0);
    send_value(32'sd1);
    send_value(-32'sd1);
    send_value(VALUE_MAX);
    send_value(VALUE_MIN);
    send_value(32'sd1_000_000_000);
    wait_drained();
  endtask

  task automatic test_radix_limits();
    apply_config(5'd2, BIN_DIGITS);
    send_value(VALUE_MIN);
    send_value(VALUE_MAX);
    wait_drained();
    apply_config(5'd16, HEX_DIGITS);
    send_value(-32'sd1);
    send_value(VALUE_MIN);
    wait_drained();
    write_reg(CFG_RADIX, 64'd17);
    send_value(32'sd5);
    wait_drained();
    write_reg(CFG_RADIX, 64'd31);
    send_value(-32'sd5);
    wait_drained();
    write_reg(CFG_RADIX, 64'd1);
    send_value(32'sd3);
    wait_drained();
  endtask

  task automatic test_alphabet_rules();
    logic [SYM_W-1:0] cases[10];
    logic [ALPHA_W-1:0] a;
    cases = '{SYM_SPACE, 8'd33, 8'd126, SYM_DEL, 8'd128, 8'd255, SYM_PLUS, SYM_MINUS,
              8'h30, 8'd0};
    foreach (cases[i]) begin
      a = DEC_DIGITS;
      a[(i == 8 ? 9 : i % 10)*SYM_W +: SYM_W] = cases[i];
      apply_config(5'd10, a);
      send_value(-32'sd123);
      wait_drained();
    end
  endtask

  task automatic test_output_holdoff();
    apply_config(5'd10, DEC_DIGITS);
    sender_idle_pct = 0;
    stall_pct = 20;
    @(posedge clk_i);
    holdoff_req = 1'b1;
    repeat (16) send_value(rand_value());
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int                 phase_sender[4] = '{0, 47, 0, 37};
    int                 phase_stall[4] = '{0, 0, 47, 37};
    logic [ALPHA_W-1:0] a;
    logic [CFG_DATA_W-1:0] data;
    logic [RADIX_W-1:0] r;
    for (int p = 0; p < 4; p++) begin
      for (int c = 0; c < 2; c++) begin
        wait_drained();
        sender_idle_pct = phase_sender[p];
        stall_pct = phase_stall[p];
        if ($urandom_range(7) == 0)
          r = $urandom_range(1) ? RADIX_W'($urandom_range(0, 1))
                                : RADIX_W'($urandom_range(17, 31));
        else
          r = RADIX_W'($urandom_range(2, 16));
        if (p == 0) r = (c == 0) ? 5'd2 : 5'd16;
        a = make_alphabet();
        if ($urandom_range(5) == 0) a[$urandom_range(15)*SYM_W +: SYM_W] = bad_symbol(a);
        data = {$urandom, $urandom};
        data[RADIX_W-1:0] = r;
        write_reg(CFG_RADIX, data);
        write_reg(CFG_ALPHA_LO, a[63:0]);
        write_reg(CFG_ALPHA_HI, a[127:64]);
        write_reg(CFG_SPARE, {$urandom, $urandom});
        if (alphabet_valid()) repeat (45) send_value(rand_value());
        else repeat (4) send_value(rand_value());
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_radix_zero();
    test_decimal_values();
    test_radix_limits();
    test_alphabet_rules();
    test_output_holdoff();
    test_random_traffic();
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
